// ===== src/bemr_pkg.sv =====
// Shared types and constants for the backward error max-ratio block.
// Used by bemr_fp_add, bemr_divider and backward_error_max_ratio_core.
`timescale 1ns / 1ps
`default_nettype none
package bemr_pkg;

   localparam logic [63:0] SAFE_MIN_BITS = 64'h0010_0000_0000_0000;
   localparam logic [63:0] POS_INF_BITS  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] POS_ZERO_BITS = 64'h0000_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES  = 11'h7FF;

   localparam int QUO_BITS = 54;   // 53 significand bits plus guard bit

   localparam logic CSR_GUARD_COUNT = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALIGN,
      S_ROUND,
      S_DIV,
      S_UPD,
      S_EMIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      D_IDLE,
      D_NORM,
      D_LOOP,
      D_ROUND,
      D_PACK
   } div_state_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_status_type;

endpackage
`default_nettype wire

// ===== src/bemr_fp_add.sv =====
// Two-step binary64 adder for non-negative finite operands.
// Align and add are registered; normalize and round follow combinationally.
// Depends on bemr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bemr_fp_add (
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [63:0] a_bits,
   input  wire logic [63:0] b_bits,
   output logic [63:0]      sum_bits
);

   logic [10:0]  ea, eb, big_e, small_e, diff;
   logic [52:0]  ma, mb, big_m, small_m;
   logic [6:0]   shamt;
   logic [116:0] small_x;
   logic [55:0]  small_a;
   logic [56:0]  sum_in;

   logic [56:0]  sum_ff;
   logic [10:0]  exp_ff;

   logic [55:0]  norm_m;
   logic [11:0]  norm_e;
   logic [52:0]  sig;
   logic         rnd_g, rnd_s, rnd_up;
   logic [62:0]  packed_v;

   always_comb begin
      ea = (a_bits[62:52] == 11'd0) ? 11'd1 : a_bits[62:52];
      eb = (b_bits[62:52] == 11'd0) ? 11'd1 : b_bits[62:52];
      ma = {(a_bits[62:52] != 11'd0), a_bits[51:0]};
      mb = {(b_bits[62:52] != 11'd0), b_bits[51:0]};
      if (eb > ea) begin
         big_e = eb; big_m = mb; small_e = ea; small_m = ma;
      end else begin
         big_e = ea; big_m = ma; small_e = eb; small_m = mb;
      end
      diff    = big_e - small_e;
      shamt   = (diff > 11'd64) ? 7'd64 : diff[6:0];
      small_x = {small_m, 64'd0} >> shamt;
      small_a = {small_x[116:62], |small_x[61:0]};
      sum_in  = {1'b0, big_m, 3'b000} + {1'b0, small_a};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
         exp_ff <= big_e;
      end
   end

   always_comb begin
      if (sum_ff[56]) begin
         norm_m = {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
         norm_e = {1'b0, exp_ff} + 12'd1;
      end else begin
         norm_m = sum_ff[55:0];
         norm_e = {1'b0, exp_ff};
      end
      sig      = norm_m[55:3];
      rnd_g    = norm_m[2];
      rnd_s    = |norm_m[1:0];
      rnd_up   = rnd_g & (rnd_s | sig[0]);
      packed_v = {norm_e[10:0], sig[51:0]} + {62'd0, rnd_up};
      if (norm_e >= {1'b0, bemr_pkg::EXP_ALL_ONES})
         sum_bits = bemr_pkg::POS_INF_BITS;
      else
         sum_bits = {1'b0, packed_v};
   end

endmodule
`default_nettype wire

// ===== src/bemr_divider.sv =====
// Radix-2 restoring binary64 divider, one quotient bit per cycle.
// Takes a positive normal dividend and a positive finite nonzero divisor.
// Depends on bemr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bemr_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] s_bits,
   input  wire logic [63:0] d_bits,
   output bemr_pkg::div_status_type status
);

   bemr_pkg::div_state_type state_ff, state_in;

   logic [52:0]        s_sig_ff, s_sig_in;
   logic [10:0]        s_exp_ff, s_exp_in;
   logic [52:0]        d_sig_ff, d_sig_in;
   logic signed [12:0] d_exp_ff, d_exp_in;
   logic [54:0]        rem_ff, rem_in;
   logic [53:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [12:0] eres_ff, eres_in;
   logic [55:0]        w_ff, w_in;
   logic               st_ff, st_in;
   logic               ovf_ff, ovf_in;
   logic [10:0]        e_ff, e_in;
   logic [63:0]        q_ff, q_in;
   logic               done_ff, done_in;

   logic [54:0]        rem_diff;
   logic               rem_ge;
   logic [55:0]        full;
   logic signed [12:0] sh;
   logic [5:0]         shc;
   logic [52:0]        sig;
   logic               rnd_up;
   logic [62:0]        packed_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bemr_pkg::D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s_sig_ff <= s_sig_in;
      s_exp_ff <= s_exp_in;
      d_sig_ff <= d_sig_in;
      d_exp_ff <= d_exp_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      eres_ff  <= eres_in;
      w_ff     <= w_in;
      st_ff    <= st_in;
      ovf_ff   <= ovf_in;
      e_ff     <= e_in;
      q_ff     <= q_in;
   end

   always_comb begin
      state_in = state_ff;
      s_sig_in = s_sig_ff;
      s_exp_in = s_exp_ff;
      d_sig_in = d_sig_ff;
      d_exp_in = d_exp_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      eres_in  = eres_ff;
      w_in     = w_ff;
      st_in    = st_ff;
      ovf_in   = ovf_ff;
      e_in     = e_ff;
      q_in     = q_ff;
      done_in  = 1'b0;

      rem_diff = rem_ff - {2'b00, d_sig_ff};
      rem_ge   = (rem_ff >= {2'b00, d_sig_ff});
      full     = {quo_ff, 2'b00};
      sh       = 13'sd1 - eres_ff;
      shc      = (sh > 13'sd56) ? 6'd56 : sh[5:0];
      sig      = w_ff[55:3];
      rnd_up   = w_ff[2] & (st_ff | w_ff[1] | w_ff[0] | sig[0]);
      packed_v = {e_ff, sig[51:0]} + {62'd0, rnd_up};

      unique case (state_ff)
         bemr_pkg::D_IDLE: begin
            if (start) begin
               s_sig_in = {1'b1, s_bits[51:0]};
               s_exp_in = s_bits[62:52];
               d_sig_in = {(d_bits[62:52] != 11'd0), d_bits[51:0]};
               d_exp_in = (d_bits[62:52] == 11'd0) ? 13'sd1
                                                    : $signed({2'b00, d_bits[62:52]});
               state_in = bemr_pkg::D_NORM;
            end
         end
         bemr_pkg::D_NORM: begin
            // shift a subnormal divisor up one place per cycle
            if (d_sig_ff[52]) begin
               if (s_sig_ff >= d_sig_ff) begin
                  rem_in  = {2'b00, s_sig_ff};
                  eres_in = $signed({2'b00, s_exp_ff}) - d_exp_ff + 13'sd1023;
               end else begin
                  rem_in  = {1'b0, s_sig_ff, 1'b0};
                  eres_in = $signed({2'b00, s_exp_ff}) - d_exp_ff + 13'sd1022;
               end
               quo_in   = '0;
               cnt_in   = 6'(bemr_pkg::QUO_BITS);
               state_in = bemr_pkg::D_LOOP;
            end else begin
               d_sig_in = {d_sig_ff[51:0], 1'b0};
               d_exp_in = d_exp_ff - 13'sd1;
            end
         end
         bemr_pkg::D_LOOP: begin
            rem_in = rem_ge ? {rem_diff[53:0], 1'b0} : {rem_ff[53:0], 1'b0};
            quo_in = {quo_ff[52:0], rem_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1)
               state_in = bemr_pkg::D_ROUND;
         end
         bemr_pkg::D_ROUND: begin
            ovf_in = (eres_ff > 13'sd2046);
            if (eres_ff > 13'sd0) begin
               w_in  = full;
               st_in = (rem_ff != 55'd0);
               e_in  = eres_ff[10:0];
            end else begin
               // subnormal result: denormalize with sticky before rounding
               w_in  = full >> shc;
               st_in = (rem_ff != 55'd0) | (|(full & ~({56{1'b1}} << shc)));
               e_in  = 11'd0;
            end
            state_in = bemr_pkg::D_PACK;
         end
         bemr_pkg::D_PACK: begin
            q_in     = ovf_ff ? bemr_pkg::POS_INF_BITS : {1'b0, packed_v};
            done_in  = 1'b1;
            state_in = bemr_pkg::D_IDLE;
         end
         default: state_in = bemr_pkg::D_IDLE;
      endcase
   end

   assign status.done     = done_ff;
   assign status.quotient = q_ff;

endmodule
`default_nettype wire

// ===== src/backward_error_max_ratio_core.sv =====
// Per element: accept, align and add, then for a divided element divisor normalization,
// the quotient-bit loop of the radix-2 divider, round and pack. A skipped element
// bypasses the divider. A column end also loads the output register.
// Synchronous reset clears the sequencer and output valid, sets the maximum to +0.0
// and the guard count to 0 (guard 2^-1022).
`timescale 1ns / 1ps
`default_nettype none
module backward_error_max_ratio_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // residual_bits[63:0], denominator_bits[127:64]
   input  wire logic         req_tlast,   // column_last
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // column_error_bits[63:0]
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   bemr_pkg::ctl_state_type state_ff, state_in;

   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic        last_ff, last_in;
   logic [63:0] max_ff, max_in;
   logic [63:0] cand_ff, cand_in;
   logic        cand_valid_ff, cand_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [15:0] count_ff, count_in;
   logic [63:0] guard_ff, guard_in;

   logic        csr_write;
   logic        add_load;
   logic        div_start;
   logic [63:0] add_sum;
   bemr_pkg::div_status_type div_status;

   logic        d_zero, d_neg, d_nan, d_inf, r_nan, r_inf, sum_inf;

   function automatic logic [63:0] guard_encode(input logic [15:0] nz);
      logic [16:0] m;
      logic [4:0]  p;
      logic [68:0] sh;
      m = {1'b0, nz} + 17'd1;
      p = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (m[i])
            p = 5'(i);
      end
      sh = {52'd0, m} << (7'd52 - {2'b00, p});
      return {1'b0, {6'd0, p} + 11'd1, sh[51:0]};
   endfunction

   bemr_fp_add u_add (
      .clock    (clock),
      .load     (add_load),
      .a_bits   ({1'b0, r_ff[62:0]}),
      .b_bits   (guard_ff),
      .sum_bits (add_sum)
   );

   // the adder result is stable while the divider takes its operands
   bemr_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .s_bits (add_sum),
      .d_bits (d_ff),
      .status (div_status)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == bemr_pkg::CSR_GUARD_COUNT) ? {16'd0, count_ff} : 32'd0;

   always_comb begin
      count_in = count_ff;
      guard_in = guard_ff;
      if (csr_write && (csr_paddr[2] == bemr_pkg::CSR_GUARD_COUNT)) begin
         count_in = csr_pwdata[15:0];
         guard_in = guard_encode(csr_pwdata[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bemr_pkg::S_IDLE;
         max_ff       <= bemr_pkg::POS_ZERO_BITS;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 16'd0;
         guard_ff     <= bemr_pkg::SAFE_MIN_BITS;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         guard_ff     <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff          <= r_in;
      d_ff          <= d_in;
      last_ff       <= last_in;
      cand_ff       <= cand_in;
      cand_valid_ff <= cand_valid_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      d_zero  = (d_ff[62:0] == 63'd0);
      d_neg   = d_ff[63];
      d_nan   = (d_ff[62:52] == bemr_pkg::EXP_ALL_ONES) && (d_ff[51:0] != 52'd0);
      d_inf   = (d_ff[62:52] == bemr_pkg::EXP_ALL_ONES) && (d_ff[51:0] == 52'd0);
      r_nan   = (r_ff[62:52] == bemr_pkg::EXP_ALL_ONES) && (r_ff[51:0] != 52'd0);
      r_inf   = (r_ff[62:52] == bemr_pkg::EXP_ALL_ONES) && (r_ff[51:0] == 52'd0);
      sum_inf = (add_sum[62:52] == bemr_pkg::EXP_ALL_ONES);
   end

   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      d_in          = d_ff;
      last_in       = last_ff;
      max_in        = max_ff;
      cand_in       = cand_ff;
      cand_valid_in = cand_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      req_tready    = 1'b0;
      add_load      = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         bemr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               r_in     = req_tdata[63:0];
               d_in     = req_tdata[127:64];
               last_in  = req_tlast;
               state_in = bemr_pkg::S_ALIGN;
            end
         end
         bemr_pkg::S_ALIGN: begin
            add_load = 1'b1;
            state_in = bemr_pkg::S_ROUND;
         end
         bemr_pkg::S_ROUND: begin
            // zero denominators and negative, NaN or zero quotients never raise the maximum: drop them
            cand_valid_in = 1'b0;
            cand_in       = bemr_pkg::POS_INF_BITS;
            state_in      = bemr_pkg::S_UPD;
            if (d_zero || d_neg || d_nan || r_nan) begin
               cand_valid_in = 1'b0;
            end else if (r_inf || sum_inf) begin
               cand_valid_in = !d_inf;
            end else if (!d_inf) begin
               div_start = 1'b1;
               state_in  = bemr_pkg::S_DIV;
            end
         end
         bemr_pkg::S_DIV: begin
            if (div_status.done) begin
               cand_in       = div_status.quotient;
               cand_valid_in = 1'b1;
               state_in      = bemr_pkg::S_UPD;
            end
         end
         bemr_pkg::S_UPD: begin
            // both operands are non-negative, so the bit patterns order like the values
            if (cand_valid_ff && (cand_ff > max_ff))
               max_in = cand_ff;
            state_in = last_ff ? bemr_pkg::S_EMIT : bemr_pkg::S_IDLE;
         end
         bemr_pkg::S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = max_ff;
               rsp_valid_in = 1'b1;
               max_in       = bemr_pkg::POS_ZERO_BITS;
               state_in     = bemr_pkg::S_IDLE;
            end
         end
         default: state_in = bemr_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_max_nonneg: assert property (@(posedge clock) disable iff (reset)
      !max_ff[63])
      else $error("running maximum went negative");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a transfer while an element is in work");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == bemr_pkg::S_DIV))
      else $error("divider finished outside the divide step");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bemr_pkg::S_EMIT) && !rsp_valid_ff) |=> rsp_tvalid)
      else $error("column result not loaded into the output register");
`endif

endmodule
`default_nettype wire

// ===== dv/backward_error_max_ratio_core_check.sv =====
// Checker for backward_error_max_ratio_core: watches the request, result and CSR
// transfers, predicts each column maximum in double arithmetic and compares.
// Depends on bemr_pkg for the safe-minimum constant and the register index.
`timescale 1ns / 1ps
`default_nettype none
module backward_error_max_ratio_core_check (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,   // residual_bits[63:0], denominator_bits[127:64]
   input  wire logic         req_tlast,   // column_last
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,   // column_error_bits[63:0]
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                fail_count,
   output int                pending
);

   logic [15:0] guard_count;
   real         column_max;
   logic [63:0] column_errors[$];

   // Fold one element into the running column maximum.
   task automatic absorb_element(input logic [63:0] res_bits, input logic [63:0] den_bits);
      real guard;
      real res_abs;
      real den;
      real ratio;
      guard   = real'(int'(guard_count) + 1) * $bitstoreal(bemr_pkg::SAFE_MIN_BITS);
      res_abs = $bitstoreal({1'b0, res_bits[62:0]});
      den     = $bitstoreal(den_bits);
      if (den != 0.0) begin
         ratio = (guard + res_abs) / den;
         // a NaN ratio fails the compare and is dropped
         if (column_max < ratio) column_max = ratio;
      end
   endtask

   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         guard_count = '0;
         column_max  = 0.0;
         column_errors.delete();
         fail_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == bemr_pkg::CSR_GUARD_COUNT)
            guard_count = csr_pwdata[15:0];
         if (req_tvalid && req_tready) begin
            absorb_element(req_tdata[63:0], req_tdata[127:64]);
            if (req_tlast) begin
               column_errors.push_back($realtobits(column_max));
               column_max = 0.0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (column_errors.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected column error transfer %h", rsp_tdata);
            end else begin
               want = column_errors.pop_front();
               if (rsp_tdata !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("column error mismatch: expected %h got %h", want, rsp_tdata);
               end
            end
         end
      end
      pending = column_errors.size();
   end

endmodule
`default_nettype wire

// ===== dv/backward_error_max_ratio_core_test.sv =====
// Top of the backward_error_max_ratio_core testbench: clock, reset, stimulus,
// backpressure and the verdict. Depends on bemr_pkg, the core and the checker.
`timescale 1ns / 1ps
`default_nettype none
module backward_error_max_ratio_core_test;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 200;   // longer than one subnormal-denominator element

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // residual_bits[63:0], denominator_bits[127:64]
   logic         req_tlast;   // column_last
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // column_error_bits[63:0]
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int fail_count;
   int pending;
   int cycles;
   int tx_idle;
   int rx_idle;
   int hold_go;
   int hold_seen;
   int hold_left;

   backward_error_max_ratio_core dut (.*);

   backward_error_max_ratio_core_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen  <= 0;
         hold_left  <= 0;
      end else if (hold_go != hold_seen) begin
         hold_seen  <= hold_go;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   function automatic logic [63:0] pick_double();
      logic [63:0] b;
      b = {$urandom, $urandom};
      case ($urandom_range(9))
         0: b[62:0] = '0;                                     // signed zero
         1: b[62:52] = '0;                                    // subnormal
         2: b[62:52] = 11'(1023 - 30 + $urandom_range(60));   // near one
         3: b[62:52] = 11'($urandom_range(1, 60));            // tiny normal
         4: b[62:52] = 11'($urandom_range(1990, 2046));       // huge
         5: b[62:0] = {bemr_pkg::EXP_ALL_ONES, 52'd0};        // infinity
         6: b[62:52] = bemr_pkg::EXP_ALL_ONES;                // NaN or infinity
         default: ;                                           // any pattern
      endcase
      return b;
   endfunction

   task automatic send_element(input logic [63:0] res, input logic [63:0] den,
                               input logic last);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {den, res};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Columns of 1..6 elements; a few stray column ends mixed in by length 1.
   task automatic random_columns(input int count);
      int n;
      int len;
      n = 0;
      while (n < count) begin
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            send_element(pick_double(), pick_double(), k == len - 1);
            n++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      tx_idle     = 0;
      rx_idle     = 0;
      hold_go     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and special cases at guard count 0.
      send_element(64'h0, 64'h3FF0_0000_0000_0000, 1'b1);                  // zero residual
      send_element(64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b1);// NaN residual
      send_element(64'h3FF0_0000_0000_0000, 64'h0, 1'b1);                  // zero denominator
      send_element(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);// minus zero
      send_element(64'h4000_0000_0000_0000, 64'hBFF0_0000_0000_0000, 1'b1);// negative ratio
      send_element(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 1'b0);// overflow
      send_element(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
      send_element(bemr_pkg::POS_INF_BITS, 64'h3FF0_0000_0000_0000, 1'b1); // infinite residual
      send_element(bemr_pkg::POS_INF_BITS, bemr_pkg::POS_INF_BITS, 1'b1);  // NaN ratio
      send_element(64'h1, bemr_pkg::POS_INF_BITS, 1'b1);
      send_element(64'h8000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 1'b0);
      send_element(64'h0, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
      send_element(64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_element(64'h3FF8_0000_0000_0000, 64'h0, 1'b0);
      send_element(64'h3FF8_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1); // all skipped
      drain();

      write_csr(3'd4, 32'hFFFF_FFFF);   // no such register
      write_csr(3'd0, 32'h0000_FFFF);   // largest guard
      tx_idle = 9;
      rx_idle = 47;
      send_element(64'h0, 64'h3FF0_0000_0000_0000, 1'b1);
      send_element(64'h0, 64'h0000_0000_0000_0001, 1'b1);
      send_element(64'h0, 64'hC000_0000_0000_0000, 1'b1);
      random_columns(180);
      drain();

      write_csr(3'd0, 32'hABCD_0000 | 32'($urandom_range(65535)));
      tx_idle = 47;
      rx_idle = 9;
      random_columns(180);
      drain();

      write_csr(3'd0, 32'h0);
      tx_idle = 0;
      rx_idle = 0;
      random_columns(60);
      hold_go = hold_go + 1;            // long result stall while elements keep coming
      random_columns(60);
      drain();
      write_csr(3'd0, 32'h1);
      random_columns(70);
      drain();

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
